// ----- design/tts_pkg.sv -----
package tts_pkg;

	// Clamp applied to the width and height registers
	localparam int unsigned MAX_DIM = 1024;

	// Texture tiles are TILE_SIDE x TILE_SIDE texels
	localparam int unsigned TILE_SIDE = 8;
	localparam int unsigned TILE_BITS = $clog2(TILE_SIDE);

	localparam int unsigned COORD_W  = 10;
	localparam int unsigned DIM_W    = 11;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned OFFSET_W = 22;
	localparam int unsigned TEXEL_W  = 32;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE = 2'd2;

	// Texel formats; codes 6 and 7 behave as the 8-bit copy
	typedef enum logic [MODE_W-1:0] {
		FMT_RGB8     = 3'd0,
		FMT_RGBA8    = 3'd1,
		FMT_RGB5551  = 3'd2,
		FMT_RGBA5551 = 3'd3,
		FMT_RGBA4444 = 3'd4,
		FMT_COPY8    = 3'd5
	} fmt_mode_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} in_word_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] byte_offset;
		logic [TEXEL_W-1:0]  texel;
		logic [COUNT_W-1:0]  byte_count;
		logic                out_of_range;
	} out_word_t;

endpackage

// ----- design/tts_texel_fmt.sv -----
module tts_texel_fmt (
	input  tts_pkg::in_word_t            pix,
	input  logic [tts_pkg::MODE_W-1:0]   format_mode,
	output logic [tts_pkg::TEXEL_W-1:0]  texel,
	output logic [tts_pkg::COUNT_W-1:0]  byte_count
);
	import tts_pkg::*;

	always_comb begin
		case (format_mode)
			FMT_RGB8: begin
				byte_count = 3'd3;
				texel      = {8'h00, pix.red, pix.green, pix.blue};
			end
			FMT_RGBA8: begin
				byte_count = 3'd4;
				texel      = {pix.red, pix.green, pix.blue, pix.alpha};
			end
			FMT_RGB5551: begin
				byte_count = 3'd2;
				texel      = {16'h0000, pix.red[7:3], pix.green[7:3], pix.blue[7:3], 1'b1};
			end
			FMT_RGBA5551: begin
				byte_count = 3'd2;
				texel      = {16'h0000, pix.red[7:3], pix.green[7:3], pix.blue[7:3],
					pix.alpha[7]};
			end
			FMT_RGBA4444: begin
				byte_count = 3'd2;
				texel      = {16'h0000, pix.red[7:4], pix.green[7:4], pix.blue[7:4],
					pix.alpha[7:4]};
			end
			default: begin
				byte_count = 3'd1;
				texel      = {24'h000000, pix.red};
			end
		endcase
	end

endmodule

// ----- design/tts_tile_addr.sv -----
module tts_tile_addr (
	input  logic                          clk,
	input  logic                          load,
	input  logic [tts_pkg::COORD_W-1:0]   column,
	input  logic [tts_pkg::COORD_W-1:0]   row,
	input  logic [tts_pkg::DIM_W-1:0]     tex_width,
	input  logic [tts_pkg::DIM_W-1:0]     tex_height,
	input  logic [tts_pkg::COUNT_W-1:0]   byte_count,
	output logic [tts_pkg::OFFSET_W-1:0]  byte_offset,
	output logic                          out_of_range
);
	import tts_pkg::*;

	localparam int unsigned TROW_W = DIM_W - TILE_BITS;
	localparam int unsigned PROD_W = TROW_W + DIM_W;
	localparam int unsigned BASE_W = PROD_W + 1;
	localparam int unsigned IDX_W  = 2 * TILE_BITS;

	logic [DIM_W-1:0]  w_clamp;
	logic [DIM_W-1:0]  h_clamp;
	logic              oor;
	logic [DIM_W-1:0]  fy;
	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0]  inner;

	logic [PROD_W-1:0]    prod_s2;
	logic [COORD_W-1:0]   col_base_s2;
	logic [IDX_W-1:0]     inner_s2;
	logic                 oor_s2;

	logic [BASE_W-1:0]    base;
	logic [OFFSET_W-1:0]  lin;
	logic [OFFSET_W-1:0]  scaled;

	// Stage A: range check, vertical flip, tile-row multiply, Morton index
	always_comb begin
		w_clamp = (tex_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_width;
		h_clamp = (tex_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_height;
		oor     = (DIM_W'(column) >= w_clamp) || (DIM_W'(row) >= h_clamp);
		fy      = h_clamp - DIM_W'(1) - DIM_W'(row);
		prod    = PROD_W'(fy[DIM_W-1:TILE_BITS]) * PROD_W'(w_clamp);
		for (int i = 0; i < TILE_BITS; i++) begin
			inner[2*i]   = column[i];
			inner[2*i+1] = fy[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2     <= prod;
			col_base_s2 <= {column[COORD_W-1:TILE_BITS], TILE_BITS'(0)};
			inner_s2    <= inner;
			oor_s2      <= oor;
		end
	end

	// Stage B: texel index within the texture, scaled by bytes per texel
	always_comb begin
		base = BASE_W'(prod_s2) + BASE_W'(col_base_s2);
		lin  = OFFSET_W'({base, TILE_BITS'(0)}) + OFFSET_W'(inner_s2);
		case (byte_count)
			3'd2:    scaled = {lin[OFFSET_W-2:0], 1'b0};
			3'd3:    scaled = lin + {lin[OFFSET_W-2:0], 1'b0};
			3'd4:    scaled = {lin[OFFSET_W-3:0], 2'b00};
			default: scaled = lin;
		endcase
		byte_offset  = oor_s2 ? '0 : scaled;
		out_of_range = oor_s2;
	end

endmodule

// ----- design/tiled_texel_swizzle_convert_unit.sv -----
// Tiled texel swizzle and format converter. Each input word carries one pixel of a
// linear, top-down image with its destination column and row; the unit flips the
// row, finds the 8x8 tile and the Morton-ordered slot inside it, and returns the
// byte offset in texture memory together with the pixel converted to the format
// selected by format_mode (RGB8, RGBA8, RGB/RGBA to 5551, RGBA to 4444, 8-bit
// copy). Coordinates outside the texture raise out_of_range and force the offset
// to zero. Throughput is one word per clock while out_ready is high; a word passes
// an input register, a register after the tile-row multiply and the output
// register, and out_valid rises as the word enters it. The three-register chain
// holds up to three words in flight, and each stage advances whenever the one after
// it is empty or being drained. Configuration (index 0 tex_width, 1 tex_height, 2
// format_mode) is written through cfg_we/cfg_index/cfg_data and must only change
// while no word is in flight.
module tiled_texel_swizzle_convert_unit (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tts_pkg::DIM_W-1:0]       cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  tts_pkg::in_word_t               in_word,

	output logic                            out_valid,
	input  logic                            out_ready,
	output tts_pkg::out_word_t              out_word
);
	import tts_pkg::*;

	// configuration
	logic [DIM_W-1:0]  tex_width_q;
	logic [DIM_W-1:0]  tex_height_q;
	logic [MODE_W-1:0] format_mode_q;

	// pipeline
	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	logic [TEXEL_W-1:0] texel_s2;
	logic [COUNT_W-1:0] count_s2;
	logic      out_valid_q;
	out_word_t out_word_q;

	logic adv_out;
	logic load_s2;
	logic [TEXEL_W-1:0]  texel_a;
	logic [COUNT_W-1:0]  count_a;
	logic [OFFSET_W-1:0] offset_b;
	logic                oor_b;

	// a stage takes a new word when it is empty or its word moves on
	assign adv_out  = !out_valid_q || out_ready;
	assign load_s2  = valid_s1 && (!valid_s2 || adv_out);
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q   <= DIM_W'(256);
			tex_height_q  <= DIM_W'(256);
			format_mode_q <= FMT_RGB8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEX_WIDTH:   tex_width_q   <= cfg_data;
				CFG_TEX_HEIGHT:  tex_height_q  <= cfg_data;
				CFG_FORMAT_MODE: format_mode_q <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || adv_out)
				valid_s2 <= valid_s1;
			if (adv_out)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			word_s1 <= in_word;
		if (load_s2) begin
			texel_s2 <= texel_a;
			count_s2 <= count_a;
		end
		if (adv_out && valid_s2) begin
			out_word_q.byte_offset  <= offset_b;
			out_word_q.texel        <= texel_s2;
			out_word_q.byte_count   <= count_s2;
			out_word_q.out_of_range <= oor_b;
		end
	end

	tts_texel_fmt u_fmt (
		.pix         (word_s1),
		.format_mode (format_mode_q),
		.texel       (texel_a),
		.byte_count  (count_a)
	);

	tts_tile_addr u_addr (
		.clk          (clk),
		.load         (load_s2),
		.column       (word_s1.column),
		.row          (word_s1.row),
		.tex_width    (tex_width_q),
		.tex_height   (tex_height_q),
		.byte_count   (count_s2),
		.byte_offset  (offset_b),
		.out_of_range (oor_b)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	// an out-of-range word never carries an address
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.out_of_range |-> out_word_q.byte_offset == '0)
		else $error("out_of_range word with nonzero byte_offset");

	// offsets of 2- and 4-byte texels stay naturally aligned
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |->
			(out_word_q.byte_count != 3'd4 || out_word_q.byte_offset[1:0] == 2'b00) &&
			(out_word_q.byte_count != 3'd2 || out_word_q.byte_offset[0] == 1'b0))
		else $error("byte_offset misaligned for byte_count");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_word_q.byte_count != 3'd0 && out_word_q.byte_count <= 3'd4)
		else $error("byte_count outside 1..4");

	// a word in the input register moves on when the middle stage is empty
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("word held in input register with middle stage empty");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import tts_pkg::*;

	// ------------------------------------------------------------------
	// Run sizing
	// ------------------------------------------------------------------
	localparam int unsigned PHASE_COUNT = 16;      // register settings in the random part
	localparam int unsigned PHASE_WORDS = 100;     // pixel words per setting
	localparam int unsigned DRAIN_CYCLES = 6;      // pipe is three deep
	localparam int unsigned CYCLE_LIMIT = 500000;  // watchdog limit, sized for heavy back-pressure
	localparam int unsigned NUM_ROWS = 23;

	// Unused register index (writes are dropped) and the two undefined
	// format codes, which fall back to the 8-bit copy.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_SPARE7 = 3'd7;

	localparam logic [DIM_W-1:0] D256 = 11'd256;
	localparam logic [DIM_W-1:0] D8   = 11'd8;
	localparam logic [DIM_W-1:0] DMAX = 11'd2047;

	typedef enum {RX_OPEN, RX_PATTERN, RX_LIGHT, RX_HEAVY} rx_style_t;

	// One row of the directed script: register setting, pixel word and,
	// where obvious, the texel word it must produce.
	typedef struct {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [MODE_W-1:0] fmt;
		in_word_t          px;
		bit                known;
		out_word_t         ans;
	} script_row_t;

	// ------------------------------------------------------------------
	// DUT signals; every input has a defined value from time zero
	// ------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TEX_WIDTH;
	logic [DIM_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_word_t             in_word = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_word;

	// Typed answer that travels with the word on the input side
	bit                   answer_known = 1'b0;
	out_word_t            answer_word = '0;

	// Shadow of the register file, updated when the sequencer writes it
	logic [DIM_W-1:0]     reg_width = 11'd256;
	logic [DIM_W-1:0]     reg_height = 11'd256;
	logic [MODE_W-1:0]    reg_mode = FMT_RGB8;

	out_word_t            pending_texels [$];
	int unsigned          mismatches = 0;
	int unsigned          words_accepted = 0;
	int unsigned          results_checked = 0;
	int unsigned          oor_seen = 0;
	int unsigned          settings_used = 0;
	int unsigned          cycle_count = 0;

	rx_style_t            rx_style = RX_OPEN;
	int unsigned          rx_left = 0;
	logic [7:0]           rx_pattern = 8'hA5;

	// Directed script. Row groups: reset setting with in-range and
	// out-of-range corners, then every format on a corner pixel, an 8x8
	// texture (last slot of the only tile), zero width, oversized registers
	// that clamp, and an odd-sized texture.
	script_row_t pixel_script [NUM_ROWS] = '{
		'{D256, D256, FMT_RGB8, '{10'd0, 10'd255, 8'h12, 8'h34, 8'h56, 8'h78},
			1'b1, '{22'h0, 32'h0012_3456, 3'd3, 1'b0}},
		'{D256, D256, FMT_RGB8, '{10'd255, 10'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
			1'b0, '0},
		'{D256, D256, FMT_RGB8, '{10'd256, 10'd0, 8'h12, 8'h34, 8'h56, 8'h00},
			1'b1, '{22'h0, 32'h0012_3456, 3'd3, 1'b1}},
		'{D256, D256, FMT_RGB8, '{10'd0, 10'd256, 8'h12, 8'h34, 8'h56, 8'h00},
			1'b1, '{22'h0, 32'h0012_3456, 3'd3, 1'b1}},
		'{D256, D256, FMT_RGB8, '{10'd1023, 10'd1023, 8'h00, 8'h00, 8'h00, 8'hFF},
			1'b1, '{22'h0, 32'h0, 3'd3, 1'b1}},
		'{D256, D256, FMT_RGBA8, '{10'd0, 10'd255, 8'h11, 8'h22, 8'h33, 8'h44},
			1'b1, '{22'h0, 32'h1122_3344, 3'd4, 1'b0}},
		'{D256, D256, FMT_RGBA8, '{10'd100, 10'd37, 8'hC3, 8'h5A, 8'h96, 8'hE1},
			1'b0, '0},
		'{D256, D256, FMT_RGB5551, '{10'd0, 10'd255, 8'hFF, 8'hFF, 8'hFF, 8'h00},
			1'b1, '{22'h0, 32'h0000_FFFF, 3'd2, 1'b0}},
		'{D256, D256, FMT_RGB5551, '{10'd0, 10'd255, 8'h00, 8'h00, 8'h00, 8'hFF},
			1'b1, '{22'h0, 32'h0000_0001, 3'd2, 1'b0}},
		'{D256, D256, FMT_RGBA5551, '{10'd0, 10'd255, 8'h00, 8'h00, 8'h00, 8'h80},
			1'b1, '{22'h0, 32'h0000_0001, 3'd2, 1'b0}},
		'{D256, D256, FMT_RGBA5551, '{10'd0, 10'd255, 8'hFF, 8'hFF, 8'hFF, 8'h7F},
			1'b1, '{22'h0, 32'h0000_FFFE, 3'd2, 1'b0}},
		'{D256, D256, FMT_RGBA4444, '{10'd0, 10'd255, 8'hF0, 8'h00, 8'h00, 8'h0F},
			1'b1, '{22'h0, 32'h0000_F000, 3'd2, 1'b0}},
		'{D256, D256, FMT_RGBA4444, '{10'd0, 10'd255, 8'h0F, 8'hF0, 8'h0F, 8'hF0},
			1'b1, '{22'h0, 32'h0000_0F0F, 3'd2, 1'b0}},
		'{D256, D256, FMT_COPY8, '{10'd0, 10'd255, 8'hAB, 8'hFF, 8'hFF, 8'hFF},
			1'b1, '{22'h0, 32'h0000_00AB, 3'd1, 1'b0}},
		'{D256, D256, MODE_SPARE6, '{10'd0, 10'd255, 8'h5A, 8'h00, 8'h00, 8'h00},
			1'b1, '{22'h0, 32'h0000_005A, 3'd1, 1'b0}},
		'{D256, D256, MODE_SPARE7, '{10'd0, 10'd255, 8'hA5, 8'hFF, 8'hFF, 8'hFF},
			1'b1, '{22'h0, 32'h0000_00A5, 3'd1, 1'b0}},
		'{D8, D8, FMT_RGBA8, '{10'd7, 10'd0, 8'h01, 8'h02, 8'h03, 8'h04},
			1'b1, '{22'h0FC, 32'h0102_0304, 3'd4, 1'b0}},
		'{D8, D8, FMT_RGBA8, '{10'd8, 10'd0, 8'h01, 8'h02, 8'h03, 8'h04},
			1'b1, '{22'h0, 32'h0102_0304, 3'd4, 1'b1}},
		'{11'd0, D256, FMT_RGBA8, '{10'd0, 10'd0, 8'h01, 8'h02, 8'h03, 8'h04},
			1'b1, '{22'h0, 32'h0102_0304, 3'd4, 1'b1}},
		'{DMAX, DMAX, FMT_RGB8, '{10'd1023, 10'd0, 8'h80, 8'h01, 8'h7F, 8'h00},
			1'b0, '0},
		'{DMAX, DMAX, FMT_RGB8, '{10'd1023, 10'd1023, 8'h01, 8'h80, 8'hFE, 8'h00},
			1'b0, '0},
		'{11'd13, 11'd9, FMT_RGB5551, '{10'd12, 10'd8, 8'h9C, 8'h63, 8'h3E, 8'h00},
			1'b0, '0},
		'{11'd13, 11'd9, FMT_RGB5551, '{10'd13, 10'd0, 8'h9C, 8'h63, 8'h3E, 8'h00},
			1'b0, '0}
	};

	tiled_texel_swizzle_convert_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Texel predictor: clamps the dimensions, flips the row, finds the
	// tile and the Morton slot, then packs the pixel for the current format.
	// ------------------------------------------------------------------
	function automatic out_word_t predict_texel(input in_word_t px);
		out_word_t         t;
		int unsigned       wlim;
		int unsigned       hlim;
		int unsigned       fy;
		int unsigned       slot;
		logic [2:0]        sx;
		logic [2:0]        sy;
		longint unsigned   ofs;
		wlim = (reg_width > MAX_DIM) ? MAX_DIM : reg_width;
		hlim = (reg_height > MAX_DIM) ? MAX_DIM : reg_height;
		t.byte_offset = '0;
		t.out_of_range = (px.column >= wlim) || (px.row >= hlim);
		case (reg_mode)
			FMT_RGB8: begin
				t.byte_count = 3'd3;
				t.texel = {8'h00, px.red, px.green, px.blue};
			end
			FMT_RGBA8: begin
				t.byte_count = 3'd4;
				t.texel = {px.red, px.green, px.blue, px.alpha};
			end
			FMT_RGB5551: begin
				t.byte_count = 3'd2;
				t.texel = {16'h0, px.red[7:3], px.green[7:3], px.blue[7:3], 1'b1};
			end
			FMT_RGBA5551: begin
				t.byte_count = 3'd2;
				t.texel = {16'h0, px.red[7:3], px.green[7:3], px.blue[7:3], px.alpha[7]};
			end
			FMT_RGBA4444: begin
				t.byte_count = 3'd2;
				t.texel = {16'h0, px.red[7:4], px.green[7:4], px.blue[7:4], px.alpha[7:4]};
			end
			default: begin
				t.byte_count = 3'd1;
				t.texel = {24'h0, px.red};
			end
		endcase
		if (!t.out_of_range) begin
			fy = hlim - 1 - px.row;
			sx = px.column[2:0];
			sy = fy[2:0];
			slot = {sy[2], sx[2], sy[1], sx[1], sy[0], sx[0]};
			ofs = (64'(fy / TILE_SIDE) * wlim + 64'(px.column & ~(TILE_SIDE - 1)))
				* TILE_SIDE * t.byte_count + 64'(slot) * t.byte_count;
			t.byte_offset = ofs[OFFSET_W-1:0];
		end
		return t;
	endfunction

	// Mostly inside the texture, sometimes right at the edge, sometimes anywhere
	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lim);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0 || lim == 0)
			return COORD_W'($urandom_range(0, 1023));
		if (sel == 1)
			return COORD_W'(lim);
		if (sel == 2)
			return COORD_W'(lim - 1);
		return COORD_W'($urandom_range(0, lim - 1));
	endfunction

	function automatic in_word_t random_pixel();
		in_word_t px;
		px.column = pick_coord((reg_width > MAX_DIM) ? MAX_DIM : reg_width);
		px.row = pick_coord((reg_height > MAX_DIM) ? MAX_DIM : reg_height);
		px.red = 8'($urandom);
		px.green = 8'($urandom);
		px.blue = 8'($urandom);
		px.alpha = 8'($urandom);
		return px;
	endfunction

	task automatic compare_word(input out_word_t want, input out_word_t got);
		if (got.byte_offset !== want.byte_offset) begin
			$error("byte_offset: expected %0h, got %0h", want.byte_offset, got.byte_offset);
			mismatches++;
		end
		if (got.texel !== want.texel) begin
			$error("texel: expected %0h, got %0h", want.texel, got.texel);
			mismatches++;
		end
		if (got.byte_count !== want.byte_count) begin
			$error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
			mismatches++;
		end
		if (got.out_of_range !== want.out_of_range) begin
			$error("out_of_range: expected %0b, got %0b", want.out_of_range,
				got.out_of_range);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Scoreboard. Both sides are sampled on the falling edge: inputs only
	// move on the rising edge, so a valid/ready pair seen here is exactly
	// what the next rising edge will accept.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_texels.push_back(answer_known ? answer_word : predict_texel(in_word));
				words_accepted++;
			end
			if (out_valid && out_ready) begin
				if (pending_texels.size() == 0) begin
					$error("unexpected result word, byte_offset %0h", out_word.byte_offset);
					mismatches++;
				end else begin
					compare_word(pending_texels.pop_front(), out_word);
					results_checked++;
					if (out_word.out_of_range === 1'b1)
						oor_seen++;
				end
			end
		end
	end

	// Receiver back-pressure: segments of random length, each either wide
	// open, a rotating 8-bit stall pattern, or light/heavy random stalls.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
			rx_pattern = 8'($urandom_range(1, 255));
		end else begin
			rx_left--;
		end
		rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
		case (rx_style)
			RX_OPEN:    out_ready <= 1'b1;
			RX_PATTERN: out_ready <= rx_pattern[0];
			RX_LIGHT:   out_ready <= ($urandom_range(0, 3) != 0);
			default:    out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer tasks; each starts and ends just after a rising edge
	// ------------------------------------------------------------------

	// Hold one word on the input until the DUT takes it
	task automatic offer(input in_word_t px, input bit known, input out_word_t ans);
		bit took;
		in_valid <= 1'b1;
		in_word <= px;
		answer_known <= known;
		answer_word <= ans;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Stop sending and wait for the pipe to empty out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_texels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Back-to-back writes of all registers, plus a dropped write to the spare index
	task automatic program_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [MODE_W-1:0] m);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TEX_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_TEX_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= CFG_FORMAT_MODE;
		cfg_data <= DIM_W'(m);
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= DIM_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_width = w;
		reg_height = h;
		reg_mode = m;
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [DIM_W-1:0]  set_w;
		logic [DIM_W-1:0]  set_h;
		logic [MODE_W-1:0] set_mode;
		int unsigned       burst_left;
		int unsigned       gap;
		bit                calm;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script: the first rows run on the reset setting with no
		// write at all; a new setting is loaded only once the pipe is empty.
		foreach (pixel_script[i]) begin
			if (pixel_script[i].w != reg_width || pixel_script[i].h != reg_height ||
					pixel_script[i].fmt != reg_mode) begin
				settle();
				program_regs(pixel_script[i].w, pixel_script[i].h, pixel_script[i].fmt);
			end
			offer(pixel_script[i].px, pixel_script[i].known, pixel_script[i].ans);
		end

		// Random part: the first settings hit the extremes (full size, clamped
		// oversize, smallest, zero, skinny, odd), the rest are drawn at random.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin set_w = DIM_W'(MAX_DIM); set_h = DIM_W'(MAX_DIM); set_mode = FMT_RGBA8; end
				1: begin set_w = DMAX; set_h = DMAX; set_mode = FMT_RGB8; end
				2: begin set_w = D8; set_h = D8; set_mode = FMT_RGBA4444; end
				3: begin set_w = 11'd0; set_h = D256; set_mode = FMT_COPY8; end
				4: begin set_w = DIM_W'(MAX_DIM); set_h = D8; set_mode = FMT_RGB5551; end
				5: begin set_w = D8; set_h = DIM_W'(MAX_DIM); set_mode = FMT_RGBA5551; end
				6: begin set_w = 11'd13; set_h = 11'd1001; set_mode = MODE_SPARE6; end
				7: begin set_w = 11'd1025; set_h = 11'd0; set_mode = MODE_SPARE7; end
				default: begin
					set_w = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 2047))
						: DIM_W'(8 * $urandom_range(1, 128));
					set_h = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 2047))
						: DIM_W'(8 * $urandom_range(1, 128));
					set_mode = MODE_W'($urandom_range(0, 7));
				end
			endcase
			settle();
			program_regs(set_w, set_h, set_mode);

			calm = (phase % 3 == 0);   // every third setting streams with no gaps
			burst_left = 0;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (burst_left == 0) begin
					gap = calm ? 0 : $urandom_range(0, 8);
					if (gap != 0) begin
						in_valid <= 1'b0;
						in_word <= random_pixel();
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
				// now and then hold off mid-stream until every result is back
				if (phase % 4 == 1 && k == PHASE_WORDS / 2)
					settle();
				offer(random_pixel(), 1'b0, '0);
				burst_left--;
			end
		end

		settle();
		$display("summary: %0d pixel words over %0d register settings, all six formats",
			words_accepted, settings_used);
		$display("summary: %0d result words compared, %0d of them outside the texture",
			results_checked, oor_seen);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
